>>> rtl/core/cone_match_particle_to_cluster_top_assert.svh
// assertion macros shared by the cone matching rtl
`ifndef CONE_MATCH_PARTICLE_TO_CLUSTER_TOP_ASSERT_SVH
`define CONE_MATCH_PARTICLE_TO_CLUSTER_TOP_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define CMPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CMPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/cmpc_pkg.sv
// types and constants shared by the cone matching modules
`timescale 1ns / 1ps

package cmpc_pkg;

  // transaction function codes
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_MATCH = 2'd2;

  // reject reason codes
  localparam logic [1:0] RSN_NONE     = 2'd0;
  localparam logic [1:0] RSN_LOW_PT   = 2'd1;
  localparam logic [1:0] RSN_ETA      = 2'd2;
  localparam logic [1:0] RSN_NO_MATCH = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ET    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_EN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_A_LO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_A_HI  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_B_LO  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_B_HI  = 3'd7;
  localparam int unsigned CFG_DATA_W = 16;

  // fixed point limits
  localparam logic [13:0]        BARREL_LIMIT = 14'd1536;
  localparam logic signed [13:0] PI_FIX       = 14'sd3217;
  localparam logic signed [13:0] TWO_PI_FIX   = 14'sd6434;

  // one stored cluster
  typedef struct packed {
    logic               region;
    logic [15:0]        et;
    logic signed [12:0] phi;
    logic signed [13:0] eta;
  } cmpc_clus_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic add;
    logic load;
    logic setup;
    logic issue;
    logic load_out;
  } cmpc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scan;
    logic count_zero;
    logic last_addr;
    logic pipe_busy;
  } cmpc_sts_t;

endpackage

>>> rtl/core/cone_match_particle_to_cluster_top.sv
// top level of the greedy cone matching block: controller plus datapath
`timescale 1ns / 1ps

// Greedy cone matching of particles to clusters, one event at a time. Each
// input transaction carries a function code: start event empties the cluster
// store, add cluster appends one cluster (dropped and flagged as overflow when
// the store already holds MAX_CLUSTERS), and match particle yields exactly one
// result transaction. Start and add produce no result. A match particle
// transaction whose pt or |eta| cut fails, that arrives with matching
// disabled, or that finds the store empty, goes from the setup state straight
// to the finish state, where its result is registered. With matching enabled
// the stored clusters are read one per cycle from the cluster memory through
// a four stage distance pipeline (memory read, delta eta and wrapped delta
// phi, squares, cone test and best pick); a match reads each of the clusters
// stored in this event, MAX_CLUSTERS at most, through the single read port of
// the store. The input is not ready while a match is in flight. A finished
// result sits in an output register, and start or add transactions are taken
// while it waits. Configuration registers are to be written by the user only
// while the block is idle; the block itself does not enforce this.

module cone_match_particle_to_cluster_top #(
  parameter int MAX_CLUSTERS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration write port
  input  logic                cfg_we,
  input  logic [cmpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cmpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input transactions
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_func,
  input  logic [15:0]         in_momentum,
  input  logic signed [13:0]  in_eta_value,
  input  logic signed [12:0]  in_phi_value,
  input  logic                in_endcap,
  // result transactions
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_accepted,
  output logic [1:0]          out_reject_reason,
  output logic                out_match_found,
  output logic [5:0]          out_match_slot,
  output logic                out_store_overflow
);
  import cmpc_pkg::*;

  // command and status between the two halves
  cmpc_cmd_t cmd;
  cmpc_sts_t sts;

  // sequencing: accept, setup, scan, drain, result
  cmpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // store, configuration, distance pipeline and result register
  cmpc_datapath #(
    .MAX_CLUSTERS (MAX_CLUSTERS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_momentum        (in_momentum),
    .in_eta_value       (in_eta_value),
    .in_phi_value       (in_phi_value),
    .in_endcap          (in_endcap),
    .cmd                (cmd),
    .sts                (sts),
    .out_accepted       (out_accepted),
    .out_reject_reason  (out_reject_reason),
    .out_match_found    (out_match_found),
    .out_match_slot     (out_match_slot),
    .out_store_overflow (out_store_overflow)
  );

endmodule

>>> rtl/core/cmpc_ctrl.sv
// controller state machine for the cone matching block
`timescale 1ns / 1ps
`include "cone_match_particle_to_cluster_top_assert.svh"

module cmpc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_func,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  cmpc_pkg::cmpc_sts_t sts,
  output cmpc_pkg::cmpc_cmd_t cmd
);
  import cmpc_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SETUP, S_SCAN, S_DRAIN, S_FINISH} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   acc;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign acc       = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_func)
            FUNC_START: cmd.start = 1'b1;
            FUNC_ADD:   cmd.add = 1'b1;
            FUNC_MATCH: begin
              cmd.load  = 1'b1;
              state_nxt = S_SETUP;
            end
            default: ;
          endcase
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        if (sts.need_scan && !sts.count_zero) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.last_addr) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `CMPC_ASSERT_NOW(a_no_overwrite, cmd.load_out, !out_valid_r || out_ready, "result overwritten")
  `CMPC_ASSERT_NOW(a_finish_drained, state_r == S_FINISH, !sts.pipe_busy, "finish before drain")
  `CMPC_ASSERT_NEXT(a_out_hold, out_valid_r && !out_ready, out_valid_r, "result dropped")

endmodule

>>> rtl/core/cmpc_datapath.sv
// cluster store, scan pipeline and result registers for the cone matching block
`timescale 1ns / 1ps
`include "cone_match_particle_to_cluster_top_assert.svh"

module cmpc_datapath #(
  parameter int MAX_CLUSTERS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [cmpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cmpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [15:0]          in_momentum,
  input  logic signed [13:0]   in_eta_value,
  input  logic signed [12:0]   in_phi_value,
  input  logic                 in_endcap,
  input  cmpc_pkg::cmpc_cmd_t  cmd,
  output cmpc_pkg::cmpc_sts_t  sts,
  output logic                 out_accepted,
  output logic [1:0]           out_reject_reason,
  output logic                 out_match_found,
  output logic [5:0]           out_match_slot,
  output logic                 out_store_overflow
);
  import cmpc_pkg::*;

  localparam int AW = $clog2(MAX_CLUSTERS);
  localparam int CW = $clog2(MAX_CLUSTERS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_CLUSTERS);

  // configuration
  logic [15:0] min_pt_r, min_et_r;
  logic [12:0] cone_r, wa_lo_r, wa_hi_r, wb_lo_r, wb_hi_r;
  logic        match_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pt_r   <= 16'd160;
      min_et_r   <= 16'd38;
      cone_r     <= 13'd102;
      match_en_r <= 1'b0;
      wa_lo_r    <= '0;
      wa_hi_r    <= '0;
      wb_lo_r    <= '0;
      wb_hi_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_PT:   min_pt_r   <= cfg_wdata;
        CFG_MIN_ET:   min_et_r   <= cfg_wdata;
        CFG_CONE:     cone_r     <= cfg_wdata[12:0];
        CFG_MATCH_EN: match_en_r <= cfg_wdata[0];
        CFG_WIN_A_LO: wa_lo_r    <= cfg_wdata[12:0];
        CFG_WIN_A_HI: wa_hi_r    <= cfg_wdata[12:0];
        CFG_WIN_B_LO: wb_lo_r    <= cfg_wdata[12:0];
        CFG_WIN_B_HI: wb_hi_r    <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  // event bookkeeping
  logic [CW-1:0] count_r;
  logic          ovf_r;
  logic          room;

  assign room = (count_r < MAX_CNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.start) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.add) begin
      if (room) begin
        count_r <= CW'(count_r + 1'b1);
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  // cluster store and taken marks
  cmpc_clus_t clus_mem [MAX_CLUSTERS];
  logic       taken_mem [MAX_CLUSTERS];
  cmpc_clus_t wr_word;
  logic [AW-1:0] scan_addr_r;
  cmpc_clus_t word_r;
  logic          tkn_r;
  logic [AW-1:0] rd_slot_r;
  logic          rd_v_r;
  logic          have_r;
  logic [AW-1:0] best_slot_r;
  logic [15:0]   best_diff_r;
  logic          scan_mode_r;

  assign wr_word = '{region: in_endcap, et: in_momentum, phi: in_phi_value,
                     eta: in_eta_value};

  always_ff @(posedge clk) begin
    if (cmd.add && room) begin
      clus_mem[count_r[AW-1:0]] <= wr_word;
    end
    if (cmd.issue) begin
      word_r <= clus_mem[scan_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add && room) begin
      taken_mem[count_r[AW-1:0]] <= 1'b0;
    end else if (cmd.load_out && scan_mode_r && have_r) begin
      taken_mem[best_slot_r] <= 1'b1;
    end
    if (cmd.issue) begin
      tkn_r <= taken_mem[scan_addr_r];
    end
  end

  // particle under test
  logic [15:0]        p_pt_r;
  logic signed [13:0] p_eta_r;
  logic signed [12:0] p_phi_r;
  logic [13:0]        p_abs_eta;
  logic               p_region;
  logic               in_win;
  logic [1:0]         reason_c, reason_r;
  logic [25:0]        r2_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_pt_r  <= in_momentum;
      p_eta_r <= in_eta_value;
      p_phi_r <= in_phi_value;
    end
  end

  assign p_abs_eta = p_eta_r[13] ? 14'(-p_eta_r) : p_eta_r;
  assign p_region  = (p_abs_eta >= BARREL_LIMIT);
  assign in_win    = ((p_abs_eta > {1'b0, wa_lo_r}) && (p_abs_eta < {1'b0, wa_hi_r})) ||
                     ((p_abs_eta > {1'b0, wb_lo_r}) && (p_abs_eta < {1'b0, wb_hi_r}));

  always_comb begin
    if (p_pt_r < min_pt_r) begin
      reason_c = RSN_LOW_PT;
    end else if (!in_win) begin
      reason_c = RSN_ETA;
    end else begin
      reason_c = RSN_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      reason_r    <= reason_c;
      scan_mode_r <= (reason_c == RSN_NONE) && match_en_r;
      r2_r        <= 26'(cone_r) * 26'(cone_r);
    end
  end

  // scan address
  logic [CW-1:0] addr_ext;
  assign addr_ext = CW'(scan_addr_r);

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      scan_addr_r <= '0;
    end else if (cmd.issue) begin
      scan_addr_r <= AW'(scan_addr_r + 1'b1);
    end
    if (cmd.issue) begin
      rd_slot_r <= scan_addr_r;
    end
  end

  // stage a: distances and eligibility
  logic signed [14:0] deta_s;
  logic signed [13:0] dphi_raw, dphi_w;
  logic [13:0]        deta_abs;
  logic [11:0]        dphi_abs;
  logic [15:0]        et_diff;
  logic               elig;
  logic               a_v_r, a_elig_r;
  logic [13:0]        a_deta_r;
  logic [11:0]        a_dphi_r;
  logic [15:0]        a_diff_r;
  logic [AW-1:0]      a_slot_r;

  assign deta_s   = $signed({p_eta_r[13], p_eta_r}) - $signed({word_r.eta[13], word_r.eta});
  assign dphi_raw = $signed({p_phi_r[12], p_phi_r}) - $signed({word_r.phi[12], word_r.phi});

  always_comb begin
    if (dphi_raw > PI_FIX) begin
      dphi_w = dphi_raw - TWO_PI_FIX;
    end else if (dphi_raw < -PI_FIX) begin
      dphi_w = dphi_raw + TWO_PI_FIX;
    end else begin
      dphi_w = dphi_raw;
    end
  end

  assign deta_abs = deta_s[14] ? 14'(-deta_s) : deta_s[13:0];
  assign dphi_abs = dphi_w[13] ? 12'(-dphi_w) : dphi_w[11:0];
  assign et_diff  = (p_pt_r >= word_r.et) ? p_pt_r - word_r.et : word_r.et - p_pt_r;
  assign elig     = !tkn_r && (word_r.region == p_region) && (word_r.et > min_et_r);

  always_ff @(posedge clk) begin
    a_deta_r <= deta_abs;
    a_dphi_r <= dphi_abs;
    a_diff_r <= et_diff;
    a_elig_r <= elig;
    a_slot_r <= rd_slot_r;
  end

  // stage b: squares
  logic          b_v_r, b_elig_r;
  logic [27:0]   b_deta_sq_r;
  logic [23:0]   b_dphi_sq_r;
  logic [15:0]   b_diff_r;
  logic [AW-1:0] b_slot_r;

  always_ff @(posedge clk) begin
    b_deta_sq_r <= 28'(a_deta_r) * 28'(a_deta_r);
    b_dphi_sq_r <= 24'(a_dphi_r) * 24'(a_dphi_r);
    b_diff_r    <= a_diff_r;
    b_elig_r    <= a_elig_r;
    b_slot_r    <= a_slot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      a_v_r  <= 1'b0;
      b_v_r  <= 1'b0;
    end else begin
      rd_v_r <= cmd.issue;
      a_v_r  <= rd_v_r;
      b_v_r  <= a_v_r;
    end
  end

  // stage c: cone test and best candidate
  logic [28:0] d2;
  logic        hit;

  assign d2  = 29'(b_deta_sq_r) + 29'(b_dphi_sq_r);
  assign hit = b_v_r && b_elig_r && (d2 < 29'(r2_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (cmd.setup) begin
      have_r <= 1'b0;
    end else if (hit && (!have_r || (b_diff_r < best_diff_r))) begin
      have_r <= 1'b1;
    end
    if (hit && (!have_r || (b_diff_r < best_diff_r))) begin
      best_slot_r <= b_slot_r;
      best_diff_r <= b_diff_r;
    end
  end

  // status
  assign sts.need_scan  = (reason_c == RSN_NONE) && match_en_r;
  assign sts.count_zero = (count_r == '0);
  assign sts.last_addr  = (CW'(addr_ext + 1'b1) == count_r);
  assign sts.pipe_busy  = rd_v_r || a_v_r || b_v_r;

  // result register
  logic [AW+5:0] slot_wide;
  logic          found;

  assign slot_wide = {6'b0, best_slot_r};
  assign found     = scan_mode_r && have_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_accepted       <= (reason_r == RSN_NONE) && (!scan_mode_r || have_r);
      out_match_found    <= found;
      out_match_slot     <= found ? slot_wide[5:0] : 6'd0;
      out_store_overflow <= ovf_r;
      if (reason_r != RSN_NONE) begin
        out_reject_reason <= reason_r;
      end else if (scan_mode_r && !have_r) begin
        out_reject_reason <= RSN_NO_MATCH;
      end else begin
        out_reject_reason <= RSN_NONE;
      end
    end
  end

  `CMPC_ASSERT_NEXT(a_best_hold, !b_v_r && !cmd.setup, $stable(have_r), "best changed off scan")
  `CMPC_ASSERT_NOW(a_slot_range, cmd.load_out && found, CW'(best_slot_r) < count_r, "bad slot")
  `CMPC_ASSERT_NOW(a_issue_range, cmd.issue, addr_ext < count_r, "read beyond fill")

endmodule

>>> dv/tb.sv
// self-checking testbench for the greedy cone matching block
`timescale 1ns / 1ps

module tb;
  import cmpc_pkg::*;

  localparam int CLUSTER_SLOTS = 64;
  localparam int BARREL_ETA = 1536;
  localparam int HALF_TURN = 3217;
  localparam int FULL_TURN = 6434;
  // function code the block ignores
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  // settling wait after the last owed result, sized from the store depth
  localparam int SETTLE_CYCLES = CLUSTER_SLOTS + 16;
  localparam int RANDOM_ITEMS = 1250;
  localparam int EVENTS_PER_SETTING = 8;
  // slowest item: a full store scan, the longest sender gap and the longest receiver stall
  localparam longint CYCLE_LIMIT = 2000000;

  // one result transaction, in port order
  typedef struct packed {
    logic       accepted;
    logic [1:0] reason;
    logic       found;
    logic [5:0] slot;
    logic       overflow;
  } match_result_t;

  // one row of the directed part: either a register write or a transaction
  typedef struct {
    bit            is_cfg;
    logic [2:0]    cfg_idx;
    logic [15:0]   cfg_val;
    logic [1:0]    func;
    logic [15:0]   mom;
    int            eta;
    int            phi;
    logic          endcap;
    bit            typed;
    match_result_t want;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_func;
  logic [15:0] in_momentum;
  logic signed [13:0] in_eta_value;
  logic signed [12:0] in_phi_value;
  logic in_endcap;
  logic out_valid;
  logic out_ready;
  logic out_accepted;
  logic [1:0] out_reject_reason;
  logic out_match_found;
  logic [5:0] out_match_slot;
  logic out_store_overflow;

  cone_match_particle_to_cluster_top #(
    .MAX_CLUSTERS(CLUSTER_SLOTS)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_momentum       (in_momentum),
    .in_eta_value      (in_eta_value),
    .in_phi_value      (in_phi_value),
    .in_endcap         (in_endcap),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_accepted      (out_accepted),
    .out_reject_reason (out_reject_reason),
    .out_match_found   (out_match_found),
    .out_match_slot    (out_match_slot),
    .out_store_overflow(out_store_overflow)
  );

  // ---------------------------------------------------------------------
  // shadow copy of the event: cluster store, taken marks, count, overflow
  // ---------------------------------------------------------------------
  int st_eta[CLUSTER_SLOTS];
  int st_phi[CLUSTER_SLOTS];
  int st_et[CLUSTER_SLOTS];
  bit st_endcap[CLUSTER_SLOTS];
  bit st_taken[CLUSTER_SLOTS];
  int st_count;
  bit st_overflow;

  // shadow copy of the register settings
  int set_min_pt;
  int set_min_et;
  int set_cone;
  bit set_match_en;
  int set_win_a_lo;
  int set_win_a_hi;
  int set_win_b_lo;
  int set_win_b_hi;

  // results still owed by the block, oldest first
  match_result_t pending_results[$];
  plan_row_t plan[$];

  int mismatch_count;
  int result_count;
  int accept_count;
  int matched_count;
  int overflow_results;
  int settings_count;
  int item_count;
  bit quiet_mode;
  longint cycle_count;

  // ---------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit, counted in clock cycles
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // shadow model
  // ---------------------------------------------------------------------
  function automatic void clear_event();
    foreach (st_taken[k]) st_taken[k] = 1'b0;
    st_count = 0;
    st_overflow = 1'b0;
  endfunction

  function automatic void reset_shadow();
    foreach (st_eta[k]) begin
      st_eta[k] = 0;
      st_phi[k] = 0;
      st_et[k] = 0;
      st_endcap[k] = 1'b0;
    end
    clear_event();
    set_min_pt = 160;
    set_min_et = 38;
    set_cone = 102;
    set_match_en = 1'b0;
    set_win_a_lo = 0;
    set_win_a_hi = 0;
    set_win_b_lo = 0;
    set_win_b_hi = 0;
  endfunction

  function automatic void apply_setting(input logic [2:0] idx, input logic [15:0] val);
    case (idx)
      CFG_MIN_PT:   set_min_pt = val;
      CFG_MIN_ET:   set_min_et = val;
      CFG_CONE:     set_cone = val[12:0];
      CFG_MATCH_EN: set_match_en = val[0];
      CFG_WIN_A_LO: set_win_a_lo = val[12:0];
      CFG_WIN_A_HI: set_win_a_hi = val[12:0];
      CFG_WIN_B_LO: set_win_b_lo = val[12:0];
      default:      set_win_b_hi = val[12:0];
    endcase
  endfunction

  // updates the shadow event for one transaction; returns 1 when a result is owed
  function automatic bit match_outcome(input logic [1:0] func, input logic [15:0] mom,
                                       input logic signed [13:0] eta_in,
                                       input logic signed [12:0] phi_in,
                                       input logic endcap, output match_result_t res);
    int eta, phi, pt, abs_eta, deta, dphi, diff, best, best_diff;
    longint dist2, cone2;
    bit have, region;
    eta = eta_in;
    phi = phi_in;
    pt = mom;
    res = '0;
    if (func == FUNC_START) begin
      clear_event();
      return 1'b0;
    end
    if (func == FUNC_ADD) begin
      if (st_count < CLUSTER_SLOTS) begin
        st_eta[st_count] = eta;
        st_phi[st_count] = phi;
        st_et[st_count] = pt;
        st_endcap[st_count] = endcap;
        st_taken[st_count] = 1'b0;
        st_count++;
      end else begin
        st_overflow = 1'b1;
      end
      return 1'b0;
    end
    if (func != FUNC_MATCH) return 1'b0;

    abs_eta = (eta < 0) ? -eta : eta;
    if (pt < set_min_pt) begin
      res.reason = RSN_LOW_PT;
    end else if (!((abs_eta > set_win_a_lo && abs_eta < set_win_a_hi) ||
                   (abs_eta > set_win_b_lo && abs_eta < set_win_b_hi))) begin
      res.reason = RSN_ETA;
    end else if (set_match_en) begin
      // search only the particle's own region; first slot wins a tie
      region = (abs_eta >= BARREL_ETA);
      cone2 = longint'(set_cone) * longint'(set_cone);
      have = 1'b0;
      best = 0;
      best_diff = 0;
      for (int k = 0; k < st_count; k++) begin
        if (st_taken[k] || st_endcap[k] != region) continue;
        if (!(st_et[k] > set_min_et)) continue;
        deta = eta - st_eta[k];
        dphi = phi - st_phi[k];
        // a single wrap by one full turn
        if (dphi > HALF_TURN) dphi -= FULL_TURN;
        else if (dphi < -HALF_TURN) dphi += FULL_TURN;
        if (deta < 0) deta = -deta;
        if (dphi < 0) dphi = -dphi;
        dist2 = longint'(deta) * deta + longint'(dphi) * dphi;
        if (!(dist2 < cone2)) continue;
        diff = (pt >= st_et[k]) ? pt - st_et[k] : st_et[k] - pt;
        if (!have || diff < best_diff) begin
          have = 1'b1;
          best = k;
          best_diff = diff;
        end
      end
      if (have) begin
        st_taken[best] = 1'b1;
        res.accepted = 1'b1;
        res.found = 1'b1;
        res.slot = best[5:0];
      end else begin
        res.reason = RSN_NO_MATCH;
      end
    end else begin
      res.accepted = 1'b1;
    end
    res.overflow = st_overflow;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------
  function automatic int clamp(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // idle length for either side: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic match_result_t rejected_as(input logic [1:0] reason);
    match_result_t r;
    r = '0;
    r.reason = reason;
    return r;
  endfunction

  // random bits above a narrow register's width, which the block must drop
  function automatic logic [15:0] with_junk(input int val, input int width);
    logic [15:0] v;
    v = val;
    if (width < 16 && $urandom_range(0, 3) == 0) v = v | 16'($urandom() << width);
    return v;
  endfunction

  // one input transaction; called just after a falling edge, returns just after a falling edge once the item is taken
  task automatic send_item(input logic [1:0] func, input logic [15:0] mom, input int eta,
                           input int phi, input logic endcap, input bit typed,
                           input match_result_t want);
    int gap;
    bit owed;
    match_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_momentum <= mom;
    in_eta_value <= eta[13:0];
    in_phi_value <= phi[12:0];
    in_endcap <= endcap;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // transaction taken at this edge
    owed = match_outcome(func, mom, eta[13:0], phi[12:0], endcap, res);
    if (owed) pending_results.push_back(typed ? want : res);
    if (func != FUNC_SPARE) item_count++;
    @(negedge clk);
  endtask

  // sender holds off until every owed result is back and the block has settled
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    apply_setting(idx, val);
    settings_count++;
    @(negedge clk);
  endtask

  task automatic add_row(input logic [1:0] func, input int mom, input int eta, input int phi,
                         input logic endcap, input bit typed, input match_result_t want);
    plan_row_t row;
    row = '{default: 0};
    row.func = func;
    row.mom = mom;
    row.eta = eta;
    row.phi = phi;
    row.endcap = endcap;
    row.typed = typed;
    row.want = want;
    plan.push_back(row);
  endtask

  task automatic add_cfg(input logic [2:0] idx, input int val);
    plan_row_t row;
    row = '{default: 0};
    row.is_cfg = 1'b1;
    row.cfg_idx = idx;
    row.cfg_val = val;
    plan.push_back(row);
  endtask

  // a new register setting for the next group of events, extremes included
  task automatic roll_settings(input int phase);
    int v[8];
    logic [2:0] idx_list[8];
    int width_list[8];
    idx_list = '{CFG_MIN_PT, CFG_MIN_ET, CFG_CONE, CFG_MATCH_EN,
                 CFG_WIN_A_LO, CFG_WIN_A_HI, CFG_WIN_B_LO, CFG_WIN_B_HI};
    width_list = '{16, 16, 13, 1, 13, 13, 13, 13};
    v[0] = $urandom_range(0, 320);
    v[1] = $urandom_range(0, 120);
    v[2] = $urandom_range(40, 500);
    v[3] = ($urandom_range(0, 5) != 0);
    v[4] = $urandom_range(0, 60);
    v[5] = $urandom_range(1000, 2600);
    v[6] = $urandom_range(1200, 2000);
    v[7] = $urandom_range(2200, 8191);
    case (phase)
      2: v = '{0, 0, 8191, 1, 0, 8191, 8191, 0};           // widest cone, lowest cuts
      4: v = '{65535, 65535, 0, 1, 8191, 8191, 0, 8191};   // highest cuts, empty cone
      6: v[3] = 0;                                         // matching off
      8: begin                                             // empty cone, no Et cut
        v[1] = 0;
        v[2] = 0;
      end
      default: ;
    endcase
    for (int i = 0; i < 8; i++) write_reg(idx_list[i], with_junk(v[i], width_list[i]));
    // some settings run with no idling on either side
    quiet_mode = ($urandom_range(0, 4) == 0);
  endtask

  task automatic send_cluster();
    int eta, phi, et, k;
    logic endcap;
    if (st_count > 0 && $urandom_range(0, 9) == 0) begin
      // copy of an earlier cluster, to make ties
      k = $urandom_range(0, clamp(st_count, 1, CLUSTER_SLOTS) - 1);
      send_item(FUNC_ADD, st_et[k], st_eta[k], st_phi[k], st_endcap[k], 1'b0, '0);
      return;
    end
    eta = ($urandom_range(0, 6) != 0) ? int'($urandom_range(0, 6000)) - 3000
                                       : int'($urandom_range(0, 16383)) - 8192;
    case ($urandom_range(0, 19))
      0, 1, 2: phi = HALF_TURN - int'($urandom_range(0, 60));     // near the wrap
      3, 4:    phi = -HALF_TURN + int'($urandom_range(0, 60));
      5:       phi = int'($urandom_range(0, 8191)) - 4096;        // beyond plus minus pi
      default: phi = int'($urandom_range(0, FULL_TURN)) - HALF_TURN;
    endcase
    case ($urandom_range(0, 9))
      0:       et = $urandom_range(0, 65535);
      1:       et = clamp(set_min_et + int'($urandom_range(0, 2)) - 1, 0, 65535);
      default: et = $urandom_range(0, 600);
    endcase
    endcap = ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1))
                                         : (eta >= BARREL_ETA || eta <= -BARREL_ETA);
    send_item(FUNC_ADD, et, eta, phi, endcap, 1'b0, '0);
  endtask

  task automatic send_particle();
    int eta, phi, pt, k, span, r;
    r = $urandom_range(0, 99);
    if (st_count > 0 && r < 70) begin
      // aim near a stored cluster so the cone search has work to do
      k = $urandom_range(0, clamp(st_count, 1, CLUSTER_SLOTS) - 1);
      span = clamp(set_cone, 0, 600) + 8;
      eta = st_eta[k] + int'($urandom_range(0, 2 * span)) - span;
      phi = st_phi[k] + int'($urandom_range(0, 2 * span)) - span;
      if (phi > HALF_TURN) phi -= FULL_TURN;
      else if (phi < -HALF_TURN) phi += FULL_TURN;
      pt = st_et[k] + int'($urandom_range(0, 80)) - 40;
    end else if (r < 85) begin
      eta = int'($urandom_range(0, 6000)) - 3000;
      phi = int'($urandom_range(0, FULL_TURN)) - HALF_TURN;
      pt = $urandom_range(0, 1000);
    end else begin
      eta = int'($urandom_range(0, 16383)) - 8192;
      phi = int'($urandom_range(0, 8191)) - 4096;
      pt = $urandom_range(0, 65535);
    end
    // boundaries of the windows and of the barrel
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 4))
        0:       eta = set_win_a_lo;
        1:       eta = set_win_a_hi;
        2:       eta = set_win_b_lo;
        3:       eta = set_win_b_hi;
        default: eta = BARREL_ETA;
      endcase
      eta = eta + int'($urandom_range(0, 2)) - 1;
      if ($urandom_range(0, 1)) eta = -eta;
    end
    if ($urandom_range(0, 9) == 0) pt = set_min_pt - int'($urandom_range(0, 1));
    send_item(FUNC_MATCH, clamp(pt, 0, 65535), clamp(eta, -8192, 8191),
              clamp(phi, -4096, 4095), 1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  task automatic send_spare();
    send_item(FUNC_SPARE, $urandom_range(0, 65535), int'($urandom_range(0, 16383)) - 8192,
              int'($urandom_range(0, 8191)) - 4096, 1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------
  // result side: random stalls, then compare against the oldest owed result
  // ---------------------------------------------------------------------
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  task automatic report_mismatch(input string field, input int got, input int want);
    if (mismatch_count < 100)
      $display("error: result %0d field %s got %0d wanted %0d", result_count, field, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    match_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unrequested transaction", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_accepted !== want.accepted)
          report_mismatch("accepted", out_accepted, want.accepted);
        if (out_reject_reason !== want.reason)
          report_mismatch("reject_reason", out_reject_reason, want.reason);
        if (out_match_found !== want.found)
          report_mismatch("match_found", out_match_found, want.found);
        if (out_match_slot !== want.slot)
          report_mismatch("match_slot", out_match_slot, want.slot);
        if (out_store_overflow !== want.overflow)
          report_mismatch("store_overflow", out_store_overflow, want.overflow);
        accept_count += want.accepted;
        matched_count += want.found;
        overflow_results += want.overflow;
      end
      result_count++;
    end
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    int phase, events, n_add, n_match;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_func = FUNC_START;
    in_momentum = '0;
    in_eta_value = '0;
    in_phi_value = '0;
    in_endcap = 1'b0;
    cycle_count = 0;
    mismatch_count = 0;
    result_count = 0;
    accept_count = 0;
    matched_count = 0;
    overflow_results = 0;
    settings_count = 0;
    item_count = 0;
    quiet_mode = 1'b0;
    reset_shadow();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, first under the reset settings: both windows are empty
    add_row(FUNC_MATCH, 0, 0, 0, 1'b0, 1'b1, rejected_as(RSN_LOW_PT));
    add_row(FUNC_MATCH, 159, 8191, 4095, 1'b1, 1'b1, rejected_as(RSN_LOW_PT));
    add_row(FUNC_MATCH, 160, 0, -4096, 1'b0, 1'b1, rejected_as(RSN_ETA));
    add_row(FUNC_MATCH, 65535, -8192, HALF_TURN, 1'b1, 1'b1, rejected_as(RSN_ETA));
    add_row(FUNC_SPARE, 65535, 8191, -HALF_TURN, 1'b1, 1'b0, '0);   // ignored code
    add_row(FUNC_ADD, 500, 0, 0, 1'b0, 1'b0, '0);                    // add with no start
    // open a barrel-side and an endcap-side window and turn matching on
    add_cfg(CFG_WIN_A_LO, 0);
    add_cfg(CFG_WIN_A_HI, 1400);
    add_cfg(CFG_WIN_B_LO, 1600);
    add_cfg(CFG_WIN_B_HI, 8191);
    add_cfg(CFG_MATCH_EN, 1);
    add_cfg(CFG_MIN_ET, 38);
    add_cfg(CFG_CONE, 102);
    add_cfg(CFG_MIN_PT, 160);
    add_row(FUNC_START, 0, 0, 0, 1'b0, 1'b0, '0);
    add_row(FUNC_ADD, 100, 100, 3200, 1'b0, 1'b0, '0);
    add_row(FUNC_ADD, 200, 100, -3200, 1'b0, 1'b0, '0);   // close only across the wrap
    add_row(FUNC_ADD, 38, 100, 100, 1'b0, 1'b0, '0);      // Et equal to the cut
    add_row(FUNC_ADD, 150, 1700, 0, 1'b1, 1'b0, '0);
    add_row(FUNC_ADD, 150, 1700, 0, 1'b1, 1'b0, '0);      // tie with the one above
    add_row(FUNC_MATCH, 190, 100, 3210, 1'b0, 1'b0, '0);  // wrapped one has closer Et
    add_row(FUNC_MATCH, 190, 100, 3210, 1'b0, 1'b0, '0);  // first is taken now
    add_row(FUNC_MATCH, 200, 100, 100, 1'b0, 1'b0, '0);   // only candidate fails Et
    add_row(FUNC_MATCH, 150, -1700, 0, 1'b0, 1'b0, '0);   // other sign of eta, so no cluster lies in the cone
    add_row(FUNC_MATCH, 150, 1700, 20, 1'b0, 1'b0, '0);
    add_row(FUNC_MATCH, 150, 1536, 0, 1'b0, 1'b0, '0);    // barrel edge counts as endcap
    add_row(FUNC_MATCH, 300, 0, 0, 1'b0, 1'b1, rejected_as(RSN_ETA));   // low bound exclusive
    add_row(FUNC_MATCH, 159, 100, 0, 1'b0, 1'b1, rejected_as(RSN_LOW_PT));
    add_row(FUNC_MATCH, 1000, -8192, 0, 1'b1, 1'b1, rejected_as(RSN_ETA));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        write_reg(plan[i].cfg_idx, plan[i].cfg_val);
      end else begin
        send_item(plan[i].func, plan[i].mom, plan[i].eta, plan[i].phi, plan[i].endcap,
                  plan[i].typed, plan[i].want);
      end
    end

    // random events: mostly well formed, with noise and broken events mixed in
    item_count = 0;
    phase = 0;
    events = 0;
    while (item_count < RANDOM_ITEMS) begin
      if (events % EVENTS_PER_SETTING == 0) begin
        wait_idle();
        roll_settings(phase);
        phase++;
      end
      events++;
      // now and then an event runs on without a start
      if ($urandom_range(0, 19) != 0)
        send_item(FUNC_START, $urandom_range(0, 65535), int'($urandom_range(0, 16383)) - 8192,
                  int'($urandom_range(0, 8191)) - 4096, 1'($urandom_range(0, 1)), 1'b0, '0);
      // some events overfill the store
      n_add = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 72) : $urandom_range(0, 10);
      n_match = $urandom_range(1, 8);
      repeat (n_add) begin
        if ($urandom_range(0, 29) == 0) send_particle();
        if ($urandom_range(0, 39) == 0) send_spare();
        send_cluster();
      end
      repeat (n_match) begin
        if ($urandom_range(0, 11) == 0) send_cluster();
        if ($urandom_range(0, 39) == 0) send_spare();
        send_particle();
      end
      if ($urandom_range(0, 29) == 0) wait_idle();
    end

    wait_idle();
    $display("ran %0d events over %0d register settings (%0d writes)", events, phase,
             settings_count);
    $display("checked %0d results: %0d accepted, %0d matched, %0d flagged overflow",
             result_count, accept_count, matched_count, overflow_results);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> cone_match_particle_to_cluster_top.f
+incdir+rtl/core
rtl/core/cmpc_pkg.sv
rtl/core/cmpc_ctrl.sv
rtl/core/cmpc_datapath.sv
rtl/core/cone_match_particle_to_cluster_top.sv
dv/tb.sv
